>>> rtl/azdft_pkg.sv
// ============================================================================
// azdft_pkg: shared types, constants and twiddle math
// Widths of the azimuthal DFT datapath and the fixed-point sin/cos series
// used to build the twiddle table at elaboration.
// ============================================================================
package azdft_pkg;

    localparam int RING_SAMPLES_DEF = 64;
    localparam int NMODES           = 63;
    localparam int MODE_OFS         = 31;
    localparam int MIDX_W           = 6;
    localparam int SAMPLE_W         = 16;
    localparam int TW_W             = 16;
    localparam int PROD_W           = 32;
    localparam int ACC_W            = 38;
    localparam int GAIN_W           = 16;
    localparam int OUT_W            = 40;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6434;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q15_MAX     = 64'd32767;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [TW_W-1:0] cos_v;
        logic signed [TW_W-1:0] sin_v;
    } twiddle_t;

    function automatic logic [TW_W-1:0] q30_to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        return (r > Q15_MAX) ? Q15_MAX[TW_W-1:0] : r[TW_W-1:0];
    endfunction

    // t is a Q0.32 fraction of a full turn
    function automatic twiddle_t twiddle_of_turn(input logic [31:0] t);
        logic [1:0]             q;
        logic [63:0]            r;
        logic [63:0]            a;
        logic [63:0]            a2;
        logic [63:0]            term;
        logic [63:0]            prod;
        logic [63:0]            sv;
        logic [63:0]            cv;
        logic signed [TW_W-1:0] sq;
        logic signed [TW_W-1:0] cq;
        twiddle_t               tw;
        q  = t[31:30];
        r  = {34'd0, t[29:0]};
        a  = (r * HALF_PI_Q30) >> 30;
        a2 = (a * a) >> 30;

        term = Q30_ONE;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd156;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd110;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd72;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd42;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd20;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd6;
        sv   = (a * term) >> 30;

        term = Q30_ONE;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd132;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd90;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd56;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd30;
        term = Q30_ONE - ((a2 * term) >> 30) / 64'd12;
        prod = ((a2 * term) >> 30) / 64'd2;
        cv   = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;

        sq = $signed(q30_to_q15(sv));
        cq = $signed(q30_to_q15(cv));
        case (q)
            QUAD_0: begin
                tw.cos_v = cq;
                tw.sin_v = sq;
            end
            QUAD_1: begin
                tw.cos_v = -sq;
                tw.sin_v = cq;
            end
            QUAD_2: begin
                tw.cos_v = -cq;
                tw.sin_v = -sq;
            end
            default: begin
                tw.cos_v = sq;
                tw.sin_v = -cq;
            end
        endcase
        return tw;
    endfunction

endpackage

>>> rtl/azimuthal_dft_modes.sv
// The ring's last sample passes the twiddle, product, emit, scale and
// output registers, then one coefficient per cycle unless m_ready stalls,
// 63 per ring (mode -31 first). The single twiddle/multiply path visits the
// 63-cell accumulator ring once per sample, taking no new one until done.
// Reset (aresetn low, synchronous): accumulators, sample count and pipeline
// cleared, gain set to 6434.
// ============================================================================
// azimuthal_dft_modes: streaming azimuthal DFT of real ring samples
// Per-sample walk over a ring of mode accumulators, scaled and emitted on
// the last sample of each ring.
// ============================================================================
module azimuthal_dft_modes #(
    parameter int RING_SAMPLES = azdft_pkg::RING_SAMPLES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [azdft_pkg::GAIN_W-1:0]           cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [azdft_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [azdft_pkg::MIDX_W-1:0]    m_mode,
    output logic signed [azdft_pkg::OUT_W-1:0]     m_coeff_real,
    output logic signed [azdft_pkg::OUT_W-1:0]     m_coeff_imag,
    output logic                                   m_last_mode
);
    import azdft_pkg::*;

    localparam int PH_W  = $clog2(RING_SAMPLES);
    localparam int SUM_W = ACC_W + 1;
    localparam int SCL_W = ACC_W + GAIN_W + 1;
    localparam int RND_W = SCL_W + 1;

    localparam logic [PH_W-1:0]   LAST_K = PH_W'(RING_SAMPLES - 1);
    localparam logic [PH_W:0]     N_EXT  = (PH_W + 1)'(RING_SAMPLES);
    localparam logic [PH_W-1:0]   MM0    =
        PH_W'((MODE_OFS * RING_SAMPLES - MODE_OFS) % RING_SAMPLES);
    localparam logic [MIDX_W-1:0] LAST_J = MIDX_W'(NMODES - 1);
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (GAIN_W - 1);

    function automatic logic [PH_W-1:0] add_mod(input logic [PH_W-1:0] a,
                                                 input logic [PH_W-1:0] b);
        logic [PH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= N_EXT) begin
            s = s - N_EXT;
        end
        return s[PH_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1] != v[SUM_W-2]) begin
            return v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return v[ACC_W-1:0];
    endfunction

    // control
    logic [GAIN_W-1:0]          gain_reg;
    logic                       iss_busy_reg;
    logic [MIDX_W-1:0]          iss_j_reg;
    logic [PH_W-1:0]            ph_reg;
    logic [PH_W-1:0]            step_reg;
    logic [PH_W-1:0]            cnt_reg;
    logic [PH_W-1:0]            start_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic                       a_valid_reg;
    logic                       b_valid_reg;
    logic                       em_valid_reg;
    logic                       sc_valid_reg;
    logic                       m_valid_reg;

    // datapath
    twiddle_t                   a_tw;
    logic signed [SAMPLE_W-1:0] a_x_reg;
    logic                       a_last_reg;
    logic [MIDX_W-1:0]          a_j_reg;
    logic signed [PROD_W-1:0]   b_pc_reg;
    logic signed [PROD_W-1:0]   b_ps_reg;
    logic                       b_last_reg;
    logic [MIDX_W-1:0]          b_j_reg;
    logic signed [ACC_W-1:0]    em_re_reg;
    logic signed [ACC_W-1:0]    em_im_reg;
    logic [MIDX_W-1:0]          em_j_reg;
    logic signed [SCL_W-1:0]    sc_re_reg;
    logic signed [SCL_W-1:0]    sc_im_reg;
    logic [MIDX_W-1:0]          sc_j_reg;
    logic signed [MIDX_W-1:0]   m_mode_reg;
    logic signed [OUT_W-1:0]    m_re_reg;
    logic signed [OUT_W-1:0]    m_im_reg;
    logic                       m_last_reg;

    logic signed [ACC_W-1:0] ring_re [NMODES+1];
    logic signed [ACC_W-1:0] ring_im [NMODES+1];

    logic                    run;
    logic                    accept;
    logic                    issue;
    logic                    shift;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic signed [ACC_W-1:0] sat_re;
    logic signed [ACC_W-1:0] sat_im;
    logic signed [RND_W-1:0] rnd_re;
    logic signed [RND_W-1:0] rnd_im;
    logic signed [RND_W-1:0] sh_re;
    logic signed [RND_W-1:0] sh_im;

    assign run     = !(m_valid_reg && !m_ready);
    assign s_ready = !iss_busy_reg && run;
    assign accept  = s_valid && s_ready;
    assign issue   = iss_busy_reg && run;
    assign shift   = b_valid_reg && run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            iss_busy_reg <= 1'b0;
            iss_j_reg    <= '0;
            ph_reg       <= '0;
            step_reg     <= '0;
            cnt_reg      <= '0;
            start_reg    <= '0;
            last_reg     <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            em_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                gain_reg <= cfg_wr_data;
            end
            if (accept) begin
                iss_busy_reg <= 1'b1;
                iss_j_reg    <= '0;
                ph_reg       <= start_reg;
                step_reg     <= cnt_reg;
                last_reg     <= (cnt_reg == LAST_K);
                if (cnt_reg == LAST_K) begin
                    cnt_reg   <= '0;
                    start_reg <= '0;
                end else begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    start_reg <= add_mod(start_reg, MM0);
                end
            end else if (issue) begin
                ph_reg    <= add_mod(ph_reg, step_reg);
                iss_j_reg <= iss_j_reg + 1'b1;
                if (iss_j_reg == LAST_J) begin
                    iss_busy_reg <= 1'b0;
                    iss_j_reg    <= '0;
                end
            end
            if (run) begin
                a_valid_reg  <= issue;
                b_valid_reg  <= a_valid_reg;
                em_valid_reg <= b_valid_reg && b_last_reg;
                sc_valid_reg <= em_valid_reg;
                m_valid_reg  <= sc_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_sample;
        end
    end

    azdft_twiddle_rom #(
        .RING_SAMPLES (RING_SAMPLES)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (issue),
        .rd_addr (ph_reg),
        .rd_data (a_tw)
    );

    assign sum_re = SUM_W'(ring_re[NMODES]) + SUM_W'(b_pc_reg);
    assign sum_im = SUM_W'(ring_im[NMODES]) - SUM_W'(b_ps_reg);
    assign sat_re = sat_acc(sum_re);
    assign sat_im = sat_acc(sum_im);

    // ring's last sample: emit the sum and restart the accumulator
    assign ring_re[0] = b_last_reg ? '0 : sat_re;
    assign ring_im[0] = b_last_reg ? '0 : sat_im;

    for (genvar i = 0; i < NMODES; i++) begin : g_ring
        azdft_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift),
            .d_re     (ring_re[i]),
            .d_im     (ring_im[i]),
            .q_re     (ring_re[i+1]),
            .q_im     (ring_im[i+1])
        );
    end

    // result fits 40 bits for any 38-bit sum and 16-bit gain
    assign rnd_re = RND_W'(sc_re_reg) + RND_HALF;
    assign rnd_im = RND_W'(sc_im_reg) + RND_HALF;
    assign sh_re  = rnd_re >>> GAIN_W;
    assign sh_im  = rnd_im >>> GAIN_W;

    always_ff @(posedge aclk) begin
        if (run) begin
            a_x_reg    <= x_reg;
            a_last_reg <= last_reg;
            a_j_reg    <= iss_j_reg;

            b_pc_reg   <= PROD_W'(a_x_reg) * PROD_W'($signed(a_tw.cos_v));
            b_ps_reg   <= PROD_W'(a_x_reg) * PROD_W'($signed(a_tw.sin_v));
            b_last_reg <= a_last_reg;
            b_j_reg    <= a_j_reg;

            em_re_reg  <= sat_re;
            em_im_reg  <= sat_im;
            em_j_reg   <= b_j_reg;

            sc_re_reg  <= SCL_W'(em_re_reg) * SCL_W'($signed({1'b0, gain_reg}));
            sc_im_reg  <= SCL_W'(em_im_reg) * SCL_W'($signed({1'b0, gain_reg}));
            sc_j_reg   <= em_j_reg;

            m_mode_reg <= MIDX_W'(sc_j_reg) - MIDX_W'(MODE_OFS);
            m_re_reg   <= sh_re[OUT_W-1:0];
            m_im_reg   <= sh_im[OUT_W-1:0];
            m_last_reg <= (sc_j_reg == LAST_J);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode       = m_mode_reg;
    assign m_coeff_real = m_re_reg;
    assign m_coeff_imag = m_im_reg;
    assign m_last_mode  = m_last_reg;

    a_last_is_top_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_mode |-> m_mode == MIDX_W'(NMODES - 1 - MODE_OFS))
        else $error("last_mode flagged on a mode other than the top one");

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_reg <= LAST_K && start_reg <= LAST_K && cnt_reg <= LAST_K)
        else $error("phase or sample counter out of ring range");

    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_valid_reg |->
            (a_j_reg == b_j_reg + 1'b1) || (b_j_reg == LAST_J && a_j_reg == '0))
        else $error("mode order broken between twiddle and product stages");

    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        !iss_busy_reg |-> iss_j_reg == '0)
        else $error("mode index not rewound after a sample");

endmodule

>>> rtl/azdft_cell.sv
// ============================================================================
// azdft_cell: one accumulator cell of the mode ring
// Holds one complex accumulator and passes it to its neighbor on shift.
// ============================================================================
module azdft_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  shift_en,
    input  logic signed [azdft_pkg::ACC_W-1:0]    d_re,
    input  logic signed [azdft_pkg::ACC_W-1:0]    d_im,
    output logic signed [azdft_pkg::ACC_W-1:0]    q_re,
    output logic signed [azdft_pkg::ACC_W-1:0]    q_im
);
    import azdft_pkg::*;

    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (shift_en) begin
            acc_re_reg <= d_re;
            acc_im_reg <= d_im;
        end
    end

    assign q_re = acc_re_reg;
    assign q_im = acc_im_reg;

endmodule

>>> rtl/azdft_twiddle_rom.sv
// ============================================================================
// azdft_twiddle_rom: cos/sin table for one ring
// Constant table of Q1.15 twiddles indexed by phase, registered read.
// ============================================================================
module azdft_twiddle_rom #(
    parameter int RING_SAMPLES = azdft_pkg::RING_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [$clog2(RING_SAMPLES)-1:0]   rd_addr,
    output azdft_pkg::twiddle_t               rd_data
);
    import azdft_pkg::*;

    twiddle_t tab [RING_SAMPLES];
    twiddle_t rd_data_reg;

    for (genvar p = 0; p < RING_SAMPLES; p++) begin : g_tab
        localparam logic [63:0] TURN = (64'(p) << 32) / RING_SAMPLES;
        localparam twiddle_t    TW   = twiddle_of_turn(TURN[31:0]);
        assign tab[p] = TW;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tab[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
